[rtl/core/ordq_pkg.sv]
// Shared constants, command codes and cell control type for the output-restricted deque.
package ordq_pkg;

    localparam int DEPTH  = 256;
    localparam int WORD_W = 64;
    localparam int CMD_W  = 3;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int S_DATA_W = ((CMD_W + WORD_W + 7) / 8) * 8;
    localparam int M_BITS   = 1 + WORD_W + 1 + CNT_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LAST   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    // One-hot row command broadcast to every cell.
    typedef struct packed {
        logic push;
        logic append;
        logic remove;
        logic clear;
    } ctrl_t;

endpackage

[rtl/core/ordq_cell.sv]
// One storage cell of the deque row: a word and its occupied flag.
module ordq_cell
    import ordq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_t             ctrl,
    input  logic [WORD_W-1:0] in_word,
    input  logic              left_occ,
    input  logic [WORD_W-1:0] left_word,
    input  logic              right_occ,
    input  logic [WORD_W-1:0] right_word,
    output logic              occ,
    output logic [WORD_W-1:0] word
);

    logic              occ_reg;
    logic [WORD_W-1:0] word_reg;
    logic              tail_hit;

    // First free slot just behind the occupied run takes an appended word.
    assign tail_hit = ctrl.append && !occ_reg && left_occ;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else if (ctrl.clear) begin
            occ_reg <= 1'b0;
        end else if (ctrl.push) begin
            occ_reg <= left_occ;
        end else if (ctrl.remove) begin
            occ_reg <= right_occ;
        end else if (tail_hit) begin
            occ_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            word_reg <= left_word;
        end else if (ctrl.remove) begin
            word_reg <= right_word;
        end else if (tail_hit) begin
            word_reg <= in_word;
        end
    end

    assign occ  = occ_reg;
    assign word = word_reg;

endmodule

[rtl/core/output_restricted_deque_64.sv]
// Top level of the output-restricted deque: command decode, cell row and result register.
//
// Bounded deque of DEPTH (256) 64-bit words held in a row of shifting cells. Push moves
// the whole row one cell back and writes the front cell, remove moves it one cell forward,
// append fills the first free cell behind the occupied run, and clear drops every
// occupied flag at once. A beat is accepted in any cycle the result register is empty
// or being drained, and its result beat appears on the master side in the next cycle.
// The front word is read from the first cell and the back word from a register that
// tracks it, so no command needs a wide read mux. There is no clearing pass after reset;
// the block accepts beats from the first cycle.
module output_restricted_deque_64
    import ordq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] cmd, [66:3] data_word, [71:67] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] ok, [64:1] value, [65] is_empty, [74:66] fill_count, [79:75] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] data_word;
    logic              accept;
    logic              is_full;
    logic              has_words;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] last_reg, last_next;
    logic              m_valid_reg;
    logic              ok_reg, ok_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic              empty_reg;
    logic [CNT_W-1:0]  fill_reg;

    ctrl_t             ctrl;
    logic [DEPTH-1:0]  occ;
    logic [WORD_W-1:0] cell_word [DEPTH];

    assign cmd       = s_tdata[CMD_W-1:0];
    assign data_word = s_tdata[CMD_W+WORD_W-1:CMD_W];

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_full   = (count_reg == FULL_CNT);
    assign has_words = (count_reg != '0);

    always_comb begin
        ctrl       = '0;
        count_next = count_reg;
        last_next  = last_reg;
        ok_next    = 1'b0;
        value_next = '0;
        case (cmd)
            CMD_PUSH: begin
                if (!is_full) begin
                    ctrl.push  = accept;
                    count_next = count_reg + CNT_ONE;
                    ok_next    = 1'b1;
                    if (!has_words) begin
                        last_next = data_word;
                    end
                end
            end
            CMD_APPEND: begin
                if (!is_full) begin
                    ctrl.append = accept;
                    count_next  = count_reg + CNT_ONE;
                    last_next   = data_word;
                    ok_next     = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (has_words) begin
                    ctrl.remove = accept;
                    count_next  = count_reg - CNT_ONE;
                    value_next  = cell_word[0];
                    ok_next     = 1'b1;
                end
            end
            CMD_FIRST: begin
                if (has_words) begin
                    value_next = cell_word[0];
                    ok_next    = 1'b1;
                end
            end
            CMD_LAST: begin
                if (has_words) begin
                    value_next = last_reg;
                    ok_next    = 1'b1;
                end
            end
            CMD_CLEAR: begin
                ctrl.clear = accept;
                count_next = '0;
                ok_next    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic              l_occ, r_occ;
            logic [WORD_W-1:0] l_word, r_word;
            if (gi == 0) begin : g_front
                assign l_occ  = 1'b1;
                assign l_word = data_word;
            end else begin : g_mid_l
                assign l_occ  = occ[gi-1];
                assign l_word = cell_word[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_back
                assign r_occ  = 1'b0;
                assign r_word = cell_word[gi];
            end else begin : g_mid_r
                assign r_occ  = occ[gi+1];
                assign r_word = cell_word[gi+1];
            end
            ordq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .in_word    (data_word),
                .left_occ   (l_occ),
                .left_word  (l_word),
                .right_occ  (r_occ),
                .right_word (r_word),
                .occ        (occ[gi]),
                .word       (cell_word[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg  <= last_next;
            ok_reg    <= ok_next;
            value_reg <= value_next;
            empty_reg <= (count_next == '0);
            fill_reg  <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - M_BITS){1'b0}}, fill_reg, empty_reg, value_reg, ok_reg};

    // The occupied run in the cell row must always match the word count.
    a_front_occ : assert property (@(posedge aclk) disable iff (!aresetn)
        occ[0] == (count_reg != '0))
        else $error("front cell occupancy disagrees with count");

    a_back_occ : assert property (@(posedge aclk) disable iff (!aresetn)
        occ[DEPTH-1] == (count_reg == FULL_CNT))
        else $error("back cell occupancy disagrees with count");

    a_occ_count : assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ) == int'(count_reg))
        else $error("occupied cells differ from count");

    a_remove_dec : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_REMOVE && has_words |=> count_reg == $past(count_reg) - CNT_ONE)
        else $error("remove did not decrement count");

    a_result_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (empty_reg == (fill_reg == '0)))
        else $error("result empty flag disagrees with fill count");

endmodule

[bench/ordq_checker.sv]
// Result checker for the output-restricted deque: mirrors its state and matches each result beat.
module ordq_checker
    import ordq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // [2:0] cmd, [66:3] data_word, [71:67] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // [0] ok, [64:1] value, [65] is_empty, [74:66] fill_count, [79:75] zero
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatch_count,
    output int                  pending_count
);

    localparam int IDX_W      = $clog2(DEPTH);
    localparam int REPORT_MAX = 10;

    // Declared from the top bit down so that ok lands in bit 0.
    typedef struct packed {
        logic [CNT_W-1:0]  fill_count;
        logic              is_empty;
        logic [WORD_W-1:0] value;
        logic              ok;
    } deque_result_t;

    logic [WORD_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]  front;
    logic [CNT_W-1:0]  held;
    deque_result_t     expected_results [$];

    function automatic logic [IDX_W-1:0] slot(input int offset);
        int pos;
        pos = (int'(front) + offset) % DEPTH;
        return pos[IDX_W-1:0];
    endfunction

    function automatic deque_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [WORD_W-1:0] word);
        deque_result_t res;
        res = '0;
        case (cmd)
            CMD_PUSH: begin
                if (held < DEPTH) begin
                    front       = slot(DEPTH - 1);
                    ring[front] = word;
                    held        = held + 1'b1;
                    res.ok      = 1'b1;
                end
            end
            CMD_APPEND: begin
                if (held < DEPTH) begin
                    ring[slot(int'(held))] = word;
                    held                   = held + 1'b1;
                    res.ok                 = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (held != 0) begin
                    res.value = ring[front];
                    front     = slot(1);
                    held      = held - 1'b1;
                    res.ok    = 1'b1;
                end
            end
            CMD_FIRST: begin
                if (held != 0) begin
                    res.value = ring[front];
                    res.ok    = 1'b1;
                end
            end
            CMD_LAST: begin
                if (held != 0) begin
                    res.value = ring[slot(int'(held) - 1)];
                    res.ok    = 1'b1;
                end
            end
            CMD_CLEAR: begin
                front  = '0;
                held   = '0;
                res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        res.is_empty   = (held == 0);
        res.fill_count = held;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        deque_result_t got;
        deque_result_t want;
        if (!aresetn) begin
            front = '0;
            held  = '0;
            expected_results.delete();
        end else begin
            // Drain first: a result beat never belongs to the command beat of the same edge.
            if (m_tvalid && m_tready) begin
                got = m_tdata[M_BITS-1:0];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result beat: ok=%0b value=%h empty=%0b fill=%0d",
                                 got.ok, got.value, got.is_empty, got.fill_count);
                end else begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok || got.value !== want.value ||
                        got.is_empty !== want.is_empty || got.fill_count !== want.fill_count) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("mismatch: expected ok=%0b value=%h empty=%0b fill=%0d, %s",
                                     want.ok, want.value, want.is_empty, want.fill_count,
                                     $sformatf("got ok=%0b value=%h empty=%0b fill=%0d",
                                               got.ok, got.value, got.is_empty,
                                               got.fill_count));
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_command(s_tdata[CMD_W-1:0],
                                                         s_tdata[CMD_W +: WORD_W]));
        end
        pending_count = expected_results.size();
    end

endmodule

[bench/tb.sv]
// Top of the deque testbench: clock, reset, command stimulus, back-pressure and verdict.
module tb;
    import ordq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    int                  mismatch_count;
    int                  pending_count;
    int                  beats_sent = 0;
    int                  cycle_count = 0;
    logic                quiet;

    output_restricted_deque_64 i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ordq_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hold both sides busy over a window of beats so back-to-back traffic gets exercised.
    assign quiet = (beats_sent >= 300) && (beats_sent < 420);

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 9);
    end

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] random_read();
        return $urandom_range(1) ? CMD_FIRST : CMD_LAST;
    endfunction

    function automatic logic [CMD_W-1:0] random_insert();
        return $urandom_range(1) ? CMD_PUSH : CMD_APPEND;
    endfunction

    function automatic logic [CMD_W-1:0] random_mix_cmd();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)      return random_insert();
        else if (pick < 65) return CMD_REMOVE;
        else if (pick < 90) return random_read();
        else if (pick < 95) return CMD_CLEAR;
        else                return $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
    endfunction

    // Called and returns at a falling edge; valid stays high into the next beat unless idling.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
        logic [S_DATA_W-1:0] beat;
        beat                   = '0;
        beat[CMD_W-1:0]        = cmd;
        beat[CMD_W +: WORD_W]  = word;
        while (!quiet && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        beats_sent++;
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty-store failures, both inserts with extreme words, spare codes, clear.
        send_beat(CMD_REMOVE, random_word());
        send_beat(CMD_FIRST, random_word());
        send_beat(CMD_LAST, random_word());
        send_beat(CMD_PUSH, '0);
        send_beat(CMD_APPEND, '1);
        send_beat(CMD_PUSH, 64'h8000_0000_0000_0000);
        send_beat(CMD_APPEND, 64'h0000_0000_0000_0001);
        send_beat(CMD_FIRST, random_word());
        send_beat(CMD_LAST, random_word());
        send_beat(CMD_SPARE_A, random_word());
        send_beat(CMD_SPARE_B, random_word());
        send_beat(CMD_REMOVE, random_word());
        send_beat(CMD_LAST, random_word());
        send_beat(CMD_CLEAR, random_word());
        send_beat(CMD_FIRST, random_word());
        send_beat(CMD_CLEAR, random_word());
        send_beat(CMD_APPEND, random_word());
        send_beat(CMD_PUSH, random_word());
        send_beat(CMD_REMOVE, random_word());
        send_beat(CMD_REMOVE, random_word());
        send_beat(CMD_REMOVE, random_word());

        // Fill to exactly DEPTH words from a known empty store, then knock on the full store.
        send_beat(CMD_CLEAR, random_word());
        for (int k = 0; k < DEPTH; k++) begin
            if ($urandom_range(9) == 0)
                send_beat(random_read(), random_word());
            send_beat(random_insert(), random_word());
        end
        repeat (6) send_beat(random_insert(), random_word());
        send_beat(random_read(), random_word());

        // Drain every word, then poke the empty store.
        for (int k = 0; k < DEPTH; k++) begin
            if ($urandom_range(9) == 0)
                send_beat(random_read(), random_word());
            send_beat(CMD_REMOVE, random_word());
        end
        repeat (4) send_beat($urandom_range(1) ? CMD_REMOVE : random_read(), random_word());

        repeat (40) send_beat(random_mix_cmd(), random_word());

        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
